[sv/pidci_pkg.sv]
// ----------------------------------------------------------------------------
// pidci_pkg
// Shared constants, register map and saturation helper for the PID block.
// ----------------------------------------------------------------------------
package pidci_pkg;

  localparam int unsigned DATA_W = 32;                 // Q16.16 field width
  localparam int unsigned FRAC_W = 16;                 // fractional bits
  localparam int unsigned PER_W  = 31;                 // step_time / integ_limit
  localparam int unsigned OPND_W = 33;                 // multiplier operand width
  localparam int unsigned HALF_W = OPND_W - FRAC_W;    // signed upper slice
  localparam int unsigned PROD_W = OPND_W + HALF_W;    // partial product
  localparam int unsigned MACC_W = 2 * OPND_W;         // full product
  localparam int unsigned TERM_W = MACC_W - FRAC_W;    // product >> 16
  localparam int unsigned SUM_W  = TERM_W + 2;         // sum of four terms
  localparam int unsigned QUO_W  = DATA_W + FRAC_W;    // |diff| << 16
  localparam int unsigned ADDR_W = 5;

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_PROP_GAIN = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [2:0] REG_FF_GAIN = 3'd3;
  localparam logic [2:0] REG_STEP_TIME = 3'd4;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;

  localparam logic [PER_W-1:0] STEP_TIME_RST = PER_W'(66);

  // saturate an exact sum to a signed 32-bit field
  function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7fff_ffff);
    lo = -SUM_W'(33'sh0_8000_0000);
    if (x > hi) begin
      sat32 = 32'h7fff_ffff;
    end else if (x < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage

[sv/pid_controller_clamped_integral.sv]
// ----------------------------------------------------------------------------
// pid_controller_clamped_integral
// PID controller in signed Q16.16 with sign-reset, clamped integral and
// measurement derivative, built around one shared 33x17 multiplier and a
// radix-2 restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | payload (lowest bits first)
//  ---------+-----+------------------+---------------------------------------
//  s_*      | in  | s_tvalid/tready  | setpoint[31:0], measured[63:32]
//  m_*      | out | m_tvalid/tready  | drive, p_term, i_term, d_term (32 each)
//  APB      | in  | psel/penable     | 6 registers at 4*i, pready tied high
//
//  Steps: an accepted item runs through the bit-serial divider (derivative,
//  one quotient bit per cycle), a step that saturates the derivative, then
//  5 products (two 33x17 slices, accumulate, post-process) and a step that
//  loads the output. Reset clears the sequencer, m_tvalid, the gains,
//  integ_limit, the integral and the last measurement and sets step_time
//  to 66; datapath registers are not reset and no sweep is needed.
//  s_tready is high only while idle. A finished result waits in the output
//  register while the next item is taken; the block stalls in its final
//  state only if the previous result is still unread.
//
module pid_controller_clamped_integral
  import pidci_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // stream in: setpoint [31:0], measured [63:32]
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,
  // stream out: drive [31:0], p_term [63:32], i_term [95:64], d_term [127:96]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [127:0]        m_tdata,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DSAT,
    ST_MUL,
    ST_POST,
    ST_OUT
  } state_t;

  // products in issue order
  typedef enum logic [2:0] {
    OP_INTEG,   // error * step_time
    OP_PROP,    // prop_gain * error
    OP_IGAIN,   // integ_gain * integral
    OP_DGAIN,   // deriv_gain * derivative
    OP_FF       // feedforward_gain * setpoint
  } op_t;

  // configuration
  logic signed [DATA_W-1:0] prop_gain;
  logic signed [DATA_W-1:0] integ_gain;
  logic signed [DATA_W-1:0] deriv_gain;
  logic signed [DATA_W-1:0] feedforward_gain;
  logic [PER_W-1:0]         step_time;
  logic [PER_W-1:0]         integ_limit;

  // loop state
  logic signed [DATA_W-1:0] integral_acc;
  logic signed [DATA_W-1:0] last_measured;

  // sequencer and per-item registers
  state_t                   state;
  op_t                      op;
  logic [1:0]               mstep;
  logic [5:0]               div_cnt;
  logic signed [DATA_W-1:0] setpoint_r;
  logic signed [OPND_W-1:0] error_r;
  logic                     diff_neg;
  logic [DATA_W-1:0]        rem_r;
  logic [QUO_W-1:0]         quo_r;      // dividend shifts out, quotient in
  logic signed [DATA_W-1:0] deriv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MACC_W-1:0] macc_r;
  logic signed [SUM_W-1:0]  drive_acc;
  logic [DATA_W-1:0]        p_r;
  logic [DATA_W-1:0]        i_r;
  logic [DATA_W-1:0]        d_r;

  // combinational helpers
  logic signed [DATA_W-1:0] sp_in;
  logic signed [DATA_W-1:0] meas_in;
  logic signed [OPND_W-1:0] diff_in;
  logic [DATA_W-1:0]        diff_mag;
  logic [PER_W-1:0]         dt_eff;
  logic [DATA_W+1:0]        trial;
  logic                     q_bit;
  logic [DATA_W-1:0]        deriv_sat;
  logic signed [OPND_W-1:0] opnd_a;
  logic signed [OPND_W-1:0] opnd_b;
  logic signed [HALF_W-1:0] b_slice;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  term_x;
  logic                     keep_integ;
  logic signed [TERM_W:0]   integ_sum;
  logic signed [TERM_W:0]   lim_pos;
  logic signed [DATA_W-1:0] integ_clamped;
  logic                     in_acc;
  logic                     cfg_wr;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign sp_in   = s_tdata[31:0];
  assign meas_in = s_tdata[63:32];
  assign diff_in = OPND_W'(meas_in) - OPND_W'(last_measured);
  // |diff| < 2^32, so the magnitude fits 32 bits
  assign diff_mag = diff_in[OPND_W-1] ? DATA_W'(-diff_in) : DATA_W'(diff_in);

  // zero period behaves as the smallest period
  assign dt_eff = (step_time == '0) ? PER_W'(1) : step_time;

  // restoring divide step
  assign trial = {1'b0, rem_r, quo_r[QUO_W-1]} - {3'b000, dt_eff};
  assign q_bit = ~trial[DATA_W+1];

  // truncated quotient, signed and saturated to 32 bits
  always_comb begin
    if (!diff_neg) begin
      deriv_sat = (quo_r[QUO_W-1:DATA_W-1] != '0) ? 32'h7fff_ffff : quo_r[DATA_W-1:0];
    end else if ((quo_r[QUO_W-1:DATA_W] != '0) ||
                 (quo_r[DATA_W-1] && (quo_r[DATA_W-2:0] != '0))) begin
      deriv_sat = 32'h8000_0000;
    end else begin
      deriv_sat = -quo_r[DATA_W-1:0];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (op)
      OP_INTEG: begin
        opnd_a = error_r;
        opnd_b = OPND_W'({1'b0, dt_eff});
      end
      OP_PROP: begin
        opnd_a = OPND_W'(prop_gain);
        opnd_b = error_r;
      end
      OP_IGAIN: begin
        opnd_a = OPND_W'(integ_gain);
        opnd_b = OPND_W'(integral_acc);
      end
      OP_DGAIN: begin
        opnd_a = OPND_W'(deriv_gain);
        opnd_b = OPND_W'(deriv_r);
      end
      OP_FF: begin
        opnd_a = OPND_W'(feedforward_gain);
        opnd_b = OPND_W'(setpoint_r);
      end
      default: begin
        opnd_a = '0;
        opnd_b = '0;
      end
    endcase
  end

  // low slice unsigned, high slice signed
  assign b_slice = (mstep == 2'd0) ? $signed({1'b0, opnd_b[FRAC_W-1:0]})
                                   : $signed(opnd_b[OPND_W-1:FRAC_W]);

  // floor(product / 2^16)
  assign term   = macc_r[MACC_W-1:FRAC_W];
  assign term_x = SUM_W'(term);

  // integral: drop on sign disagreement, add increment, clamp to +/- limit
  assign keep_integ = ((error_r > 0) && (integral_acc > 0)) ||
                      ((error_r <= 0) && (integral_acc < 0));
  assign integ_sum  = (TERM_W + 1)'(term) +
                      (keep_integ ? (TERM_W + 1)'(integral_acc) : '0);
  assign lim_pos    = (TERM_W + 1)'({1'b0, integ_limit});

  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_clamped = DATA_W'(lim_pos);
    end else if (integ_sum < -lim_pos) begin
      integ_clamped = DATA_W'(-lim_pos);
    end else begin
      integ_clamped = integ_sum[DATA_W-1:0];
    end
  end

  // register read-back
  always_comb begin
    case (paddr[4:2])
      REG_PROP_GAIN:   prdata = prop_gain;
      REG_INTEG_GAIN:  prdata = integ_gain;
      REG_DERIV_GAIN:  prdata = deriv_gain;
      REG_FF_GAIN:     prdata = feedforward_gain;
      REG_STEP_TIME:   prdata = {1'b0, step_time};
      REG_INTEG_LIMIT: prdata = {1'b0, integ_limit};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      op               <= OP_INTEG;
      mstep            <= '0;
      div_cnt          <= '0;
      m_tvalid         <= 1'b0;
      prop_gain        <= '0;
      integ_gain       <= '0;
      deriv_gain       <= '0;
      feedforward_gain <= '0;
      step_time        <= STEP_TIME_RST;
      integ_limit      <= '0;
      integral_acc     <= '0;
      last_measured    <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_PROP_GAIN:   prop_gain        <= pwdata;
          REG_INTEG_GAIN:  integ_gain       <= pwdata;
          REG_DERIV_GAIN:  deriv_gain       <= pwdata;
          REG_FF_GAIN:     feedforward_gain <= pwdata;
          REG_STEP_TIME:   step_time        <= pwdata[PER_W-1:0];
          REG_INTEG_LIMIT: integ_limit      <= pwdata[PER_W-1:0];
          default: ;
        endcase
      end

      // in the final state the output register is reloaded instead
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            setpoint_r    <= sp_in;
            error_r       <= OPND_W'(sp_in) - OPND_W'(meas_in);
            diff_neg      <= diff_in[OPND_W-1];
            quo_r         <= {diff_mag, {FRAC_W{1'b0}}};
            rem_r         <= '0;
            last_measured <= meas_in;
            div_cnt       <= 6'(QUO_W - 1);
            state         <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= q_bit ? trial[DATA_W-1:0] : {rem_r[DATA_W-2:0], quo_r[QUO_W-1]};
          quo_r <= {quo_r[QUO_W-2:0], q_bit};
          if (div_cnt == '0) begin
            state <= ST_DSAT;
          end else begin
            div_cnt <= div_cnt - 6'd1;
          end
        end
        ST_DSAT: begin
          deriv_r <= deriv_sat;
          op      <= OP_INTEG;
          mstep   <= '0;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          // low slice, then high slice while the low product is taken in,
          // then add the high product at weight 2^16
          case (mstep)
            2'd0: begin
              prod_r <= opnd_a * b_slice;
              mstep  <= 2'd1;
            end
            2'd1: begin
              macc_r <= MACC_W'(prod_r);
              prod_r <= opnd_a * b_slice;
              mstep  <= 2'd2;
            end
            default: begin
              macc_r <= macc_r + {prod_r, {FRAC_W{1'b0}}};
              mstep  <= 2'd0;
              state  <= ST_POST;
            end
          endcase
        end
        ST_POST: begin
          state <= ST_MUL;
          case (op)
            OP_INTEG: begin
              integral_acc <= integ_clamped;
              op           <= OP_PROP;
            end
            OP_PROP: begin
              p_r       <= sat32(term_x);
              drive_acc <= term_x;
              op        <= OP_IGAIN;
            end
            OP_IGAIN: begin
              i_r       <= sat32(term_x);
              drive_acc <= drive_acc + term_x;
              op        <= OP_DGAIN;
            end
            OP_DGAIN: begin
              d_r       <= sat32(term_x);
              drive_acc <= drive_acc - term_x;
              op        <= OP_FF;
            end
            default: begin
              drive_acc <= drive_acc + term_x;
              op        <= OP_INTEG;
              state     <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          // wait for the previous result to leave
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {d_r, i_r, p_r, sat32(drive_acc)};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
